// File: hdl/swme_pkg.sv
// Shared codes and widths for the slotted wheel motor encoder model.
package swme_pkg;

    localparam int ACTION_W    = 2;
    localparam int DIRECTION_W = 2;
    localparam int COUNT_W     = 16;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

    // direction codes
    localparam logic [DIRECTION_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIRECTION_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIRECTION_W-1:0] DIR_BWD  = 2'd2;

    // coarse start position of each wheel, before fine scaling
    localparam int START_COARSE = 60;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic                   motor_select;
        logic [DIRECTION_W-1:0] direction_code;
    } swme_item_t;

endpackage

// File: hdl/slotted_wheel_motor_encoder_model_core.sv
// Top level: motor positions, directions and encoder pulse counters.
//
//  channel | ports        | payload
//  --------+--------------+-----------------------------------------------
//  input   | s_tvalid/rdy | tuser: action, motor_select; tdata: direction
//  result  | m_tvalid/rdy | tdata: pulse_count (read items only)
//
// Each item is held in the input register until it is executed; a read result
// is loaded into the output register at the same edge that executes the read
// and is offered from the following cycle.
// One item per cycle sustained; the input register stalls only when it holds
// a read and the output register is full and not being taken.
// Reset (aresetn low, synchronous) restores positions, stops all motors and
// clears the pulse counters.
module slotted_wheel_motor_encoder_model_core #(
    parameter int HOLE_COUNT        = 20,
    parameter int MASKED_HOLE_COUNT = 3,
    parameter int WHEEL_POSITIONS   = 100,
    parameter int FINE_SHIFT        = 1,
    parameter int MOTOR_COUNT       = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] direction_code, [7:2] zero
    input  logic [2:0]  s_tuser,   // [1:0] action, [2] motor_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] pulse_count
);
    import swme_pkg::*;

    localparam int FINE_PERIOD = WHEEL_POSITIONS << FINE_SHIFT;
    localparam int START_FINE  = START_COARSE << FINE_SHIFT;
    localparam int POS_LIMIT   = (START_FINE > FINE_PERIOD - 1) ? START_FINE : FINE_PERIOD - 1;
    localparam int POS_W       = $clog2(POS_LIMIT + 1);
    localparam int COARSE_W    = POS_W - FINE_SHIFT;
    localparam int TABLE_DEPTH = 1 << COARSE_W;
    localparam int MOT_W       = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    function automatic logic [TABLE_DEPTH-1:0] build_slots();
        logic [TABLE_DEPTH-1:0] t;
        t = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i < WHEEL_POSITIONS) begin
                if ((((i * 2 * HOLE_COUNT) / WHEEL_POSITIONS) % 2) == 1)
                    t[i] = 1'b1;
                if ((i * HOLE_COUNT) / WHEEL_POSITIONS >= HOLE_COUNT - MASKED_HOLE_COUNT)
                    t[i] = 1'b1;
            end
        end
        return t;
    endfunction

    localparam logic [TABLE_DEPTH-1:0] SLOT_TABLE = build_slots();

    swme_item_t             item_reg;
    logic                   item_valid_reg;
    logic                   out_valid_reg;
    logic [COUNT_W-1:0]     out_data_reg;

    logic [POS_W-1:0]       pos_reg   [MOTOR_COUNT];
    logic [POS_W-1:0]       pos_next  [MOTOR_COUNT];
    logic [DIRECTION_W-1:0] dir_reg   [MOTOR_COUNT];
    logic [COUNT_W-1:0]     cnt_reg   [MOTOR_COUNT];
    logic [COUNT_W-1:0]     cnt_next  [MOTOR_COUNT];

    logic                   out_free;
    logic                   exec;
    logic                   is_read;
    logic [MOT_W-1:0]       sel_idx;
    logic [DIRECTION_W-1:0] dir_store;

    assign is_read  = (item_reg.action == ACT_READ);
    assign out_free = !out_valid_reg || m_tready;
    assign exec     = item_valid_reg && (!is_read || out_free);
    assign s_tready = !item_valid_reg || exec;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        sel_idx = MOT_W'(item_reg.motor_select);
        if (int'(item_reg.motor_select) >= MOTOR_COUNT)
            sel_idx = MOT_W'(MOTOR_COUNT - 1);
    end

    assign dir_store = (item_reg.direction_code >= DIR_BWD) ? DIR_BWD : item_reg.direction_code;

    // per-motor step: move, wrap into the wheel, count rising slot edges
    always_comb begin
        for (int k = 0; k < MOTOR_COUNT; k++) begin
            logic [POS_W:0]      t;
            logic [COARSE_W-1:0] c_old;
            logic [COARSE_W-1:0] c_new;
            unique case (dir_reg[k])
                DIR_FWD: t = {1'b0, pos_reg[k]} + 1'b1;
                DIR_BWD: begin
                    if (pos_reg[k] == '0)
                        t = (POS_W+1)'(FINE_PERIOD - 1);
                    else
                        t = {1'b0, pos_reg[k]} - 1'b1;
                end
                default: t = {1'b0, pos_reg[k]};
            endcase
            if (t >= (POS_W+1)'(FINE_PERIOD))
                t = t - (POS_W+1)'(FINE_PERIOD);
            pos_next[k] = t[POS_W-1:0];
            c_old = pos_reg[k][POS_W-1:FINE_SHIFT];
            c_new = t[POS_W-1:FINE_SHIFT];
            if (!SLOT_TABLE[c_old] && SLOT_TABLE[c_new])
                cnt_next[k] = cnt_reg[k] + 1'b1;
            else
                cnt_next[k] = cnt_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                pos_reg[k] <= POS_W'(START_FINE);
                dir_reg[k] <= DIR_STOP;
                cnt_reg[k] <= '0;
            end
        end else begin
            if (s_tready) begin
                item_valid_reg <= s_tvalid;
            end
            if (exec && is_read) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (exec) begin
                unique case (item_reg.action)
                    ACT_TICK: begin
                        for (int k = 0; k < MOTOR_COUNT; k++) begin
                            pos_reg[k] <= pos_next[k];
                            cnt_reg[k] <= cnt_next[k];
                        end
                    end
                    ACT_SET:  dir_reg[sel_idx] <= dir_store;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.action         <= s_tuser[1:0];
            item_reg.motor_select   <= s_tuser[2];
            item_reg.direction_code <= s_tdata[1:0];
        end
        if (exec && is_read) begin
            out_data_reg <= cnt_reg[sel_idx];
        end
    end

endmodule

// File: hdl/swme_checker.sv
// Port-level checks for the encoder model core, bound to the top level.
module swme_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import swme_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // input backpressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // a fresh result follows an accepted read item through the input and output registers
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser[1:0] == ACT_READ), 2))
        else $error("result without a read item");

endmodule

bind slotted_wheel_motor_encoder_model_core swme_checker u_swme_checker (.*);

// File: verif/testbench.sv
// Self-checking testbench for the slotted wheel motor encoder core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import swme_pkg::*;

    localparam int HOLE_COUNT        = 20;
    localparam int MASKED_HOLE_COUNT = 3;
    localparam int WHEEL_POSITIONS   = 100;
    localparam int FINE_SHIFT        = 1;
    localparam int MOTOR_COUNT       = 2;
    localparam int FINE_PERIOD       = WHEEL_POSITIONS << FINE_SHIFT;

    localparam logic [ACTION_W-1:0]    ACT_NONE    = 2'd3;   // unused action code
    localparam logic [DIRECTION_W-1:0] DIR_SPARE   = 2'd3;   // unused, acts as backward
    localparam int                     RANDOM_ITEMS = 1280;
    localparam int                     MAX_GAP      = 18;
    localparam int                     HOLD_CYCLES  = 300;
    localparam int                     WATCHDOG_LIMIT = 2000;

    typedef struct {
        swme_item_t it;
        int         gap;
        int         reps;
        bit         drain;
        bit         hold;
    } stim_entry_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [1:0] direction_code, [7:2] zero
    logic [2:0]  s_tuser  = '0;   // [1:0] action, [2] motor_select
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [15:0] pulse_count

    always #5ns aclk = ~aclk;

    slotted_wheel_motor_encoder_model_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // encoder state as the block should hold it
    int                     fine_pos    [MOTOR_COUNT];
    logic [DIRECTION_W-1:0] heading     [MOTOR_COUNT];
    logic [COUNT_W-1:0]     pulse_tally [MOTOR_COUNT];
    logic [COUNT_W-1:0]     pulses_due[$];

    stim_entry_t pending[$];
    stim_entry_t cur;
    bit          have_cur = 1'b0;
    int          gap_left = 0;
    logic        hold_req = 1'b0;

    int total_items  = 0;
    int items_done   = 0;
    int ticks_done   = 0;
    int sets_done    = 0;
    int noops_done   = 0;
    int results_seen = 0;
    int faults       = 0;
    int idle_cycles  = 0;

    int stall_left = 0;
    int hold_left  = 0;
    bit rx_calm    = 1'b0;

    function automatic bit slot_open(int coarse);
        if (coarse < 0 || coarse >= WHEEL_POSITIONS)
            return 1'b0;
        return ((coarse * 2 * HOLE_COUNT / WHEEL_POSITIONS) % 2 == 1) ||
               (coarse * HOLE_COUNT / WHEEL_POSITIONS >= HOLE_COUNT - MASKED_HOLE_COUNT);
    endfunction

    function automatic int pick_motor(logic sel);
        int m;
        m = int'(sel);
        if (m >= MOTOR_COUNT)
            m = MOTOR_COUNT - 1;
        return m;
    endfunction

    task automatic clear_encoders();
        for (int k = 0; k < MOTOR_COUNT; k++) begin
            fine_pos[k]    = START_COARSE << FINE_SHIFT;
            heading[k]     = DIR_STOP;
            pulse_tally[k] = '0;
        end
    endtask

    task automatic step_encoders(swme_item_t it);
        int pos;
        bit was_open;
        int m;
        m = pick_motor(it.motor_select);
        case (it.action)
            ACT_TICK: begin
                ticks_done++;
                for (int k = 0; k < MOTOR_COUNT; k++) begin
                    pos = fine_pos[k];
                    was_open = slot_open(pos >>> FINE_SHIFT);
                    if (heading[k] == DIR_FWD)
                        pos++;
                    else if (heading[k] == DIR_BWD)
                        pos--;
                    if (pos < 0)
                        pos += FINE_PERIOD;
                    if (pos >= FINE_PERIOD)
                        pos -= FINE_PERIOD;
                    fine_pos[k] = pos;
                    if (!was_open && slot_open(pos >>> FINE_SHIFT))
                        pulse_tally[k] = pulse_tally[k] + 1'b1;
                end
            end
            ACT_SET: begin
                sets_done++;
                heading[m] = (it.direction_code >= DIR_BWD) ? DIR_BWD : it.direction_code;
            end
            ACT_READ: pulses_due.push_back(pulse_tally[m]);
            default: noops_done++;
        endcase
    endtask

    task automatic enqueue(logic [ACTION_W-1:0] act, logic sel, logic [DIRECTION_W-1:0] code,
                           int gap, int reps, bit drain, bit hold);
        stim_entry_t e;
        e.it.action         = act;
        e.it.motor_select   = sel;
        e.it.direction_code = code;
        e.gap   = gap;
        e.reps  = reps;
        e.drain = drain;
        e.hold  = hold;
        pending.push_back(e);
        total_items += reps;
    endtask

    task automatic report_fault(string what, logic [15:0] want, logic [15:0] got);
        faults++;
        if (faults <= 10)
            $display("[%0t] %s: pulse_count expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // sender
    always @(posedge aclk) begin : drive
        bit fire;
        bit launch;
        bit next_valid;
        fire = s_tvalid && s_tready;
        launch = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            hold_req <= 1'b0;
            clear_encoders();
        end else begin
            if (fire) begin
                step_encoders(cur.it);
                items_done++;
                if (cur.reps > 1)
                    cur.reps--;
                else
                    have_cur = 1'b0;
            end
            if (!have_cur && pending.size() > 0) begin
                cur = pending.pop_front();
                have_cur = 1'b1;
                gap_left = cur.gap;
            end
            next_valid = s_tvalid && !fire;
            if (have_cur && !next_valid) begin
                if (gap_left > 0)
                    gap_left--;
                else if (!cur.drain || pulses_due.size() == 0)
                    launch = 1'b1;
            end
            if (launch) begin
                s_tdata <= {6'b0, cur.it.direction_code};
                s_tuser <= {cur.it.motor_select, cur.it.action};
            end
            s_tvalid <= next_valid || launch;
            hold_req <= launch && cur.hold;
        end
    end

    // receiver and checker
    always @(posedge aclk) begin : receive
        logic [15:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pulses_due.size() == 0) begin
                    report_fault("unexpected result", 'x, m_tdata);
                end else begin
                    want = pulses_due.pop_front();
                    if (m_tdata !== want)
                        report_fault("mismatch", want, m_tdata);
                end
                stall_left = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
            end else if (!m_tready && stall_left > 0) begin
                stall_left--;
            end
            if (hold_req)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (stall_left == 0);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL slotted_wheel_motor_encoder_model_core");
            $finish;
        end
    end

    initial begin : stimulus
        int gap_mode;
        int gap;
        int pick;
        int reps;
        int n;
        int mode_mark;
        bit burst_done;

        // directed: reset counts, every action, spare codes, short moves, full turns both ways
        enqueue(ACT_READ, 1'b0, DIR_STOP, 0, 1, 1'b0, 1'b0);
        enqueue(ACT_READ, 1'b1, DIR_SPARE, 0, 1, 1'b0, 1'b0);
        enqueue(ACT_TICK, 1'b0, DIR_STOP, 0, 3, 1'b0, 1'b0);
        enqueue(ACT_NONE, 1'b1, DIR_SPARE, 2, 1, 1'b0, 1'b0);
        enqueue(ACT_NONE, 1'b0, DIR_STOP, 0, 1, 1'b0, 1'b0);
        enqueue(ACT_SET, 1'b0, DIR_FWD, 0, 1, 1'b0, 1'b0);
        enqueue(ACT_SET, 1'b1, DIR_SPARE, 1, 1, 1'b0, 1'b0);
        enqueue(ACT_TICK, 1'b0, DIR_STOP, 0, 25, 1'b0, 1'b0);
        enqueue(ACT_READ, 1'b0, DIR_STOP, 0, 1, 1'b0, 1'b0);
        enqueue(ACT_READ, 1'b1, DIR_STOP, 0, 1, 1'b0, 1'b0);
        enqueue(ACT_SET, 1'b1, DIR_BWD, 3, 1, 1'b0, 1'b0);
        enqueue(ACT_SET, 1'b0, DIR_STOP, 0, 1, 1'b0, 1'b0);
        enqueue(ACT_TICK, 1'b1, DIR_SPARE, 0, 60, 1'b0, 1'b0);
        enqueue(ACT_READ, 1'b0, DIR_SPARE, 0, 1, 1'b0, 1'b0);
        enqueue(ACT_READ, 1'b1, DIR_FWD, 0, 1, 1'b0, 1'b0);
        enqueue(ACT_SET, 1'b1, DIR_FWD, 0, 1, 1'b0, 1'b0);
        enqueue(ACT_SET, 1'b0, DIR_BWD, 0, 1, 1'b0, 1'b0);
        enqueue(ACT_TICK, 1'b0, DIR_STOP, 0, 210, 1'b0, 1'b0);
        enqueue(ACT_READ, 1'b0, DIR_STOP, 5, 1, 1'b1, 1'b0);
        enqueue(ACT_READ, 1'b1, DIR_STOP, 0, 1, 1'b0, 1'b0);

        gap_mode = 0;
        n = 0;
        mode_mark = 0;
        burst_done = 1'b0;
        while (n < RANDOM_ITEMS) begin
            if (n >= mode_mark) begin
                gap_mode = $urandom_range(0, 2);
                mode_mark += 100;
            end
            case (gap_mode)
                0: gap = 0;
                1: gap = $urandom_range(0, MAX_GAP);
                default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
            endcase
            if (!burst_done && n >= 400) begin
                // receiver stops for a while; back-to-back reads must back up
                enqueue(ACT_READ, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                        0, 1, 1'b0, 1'b1);
                for (int r = 0; r < 40; r++)
                    enqueue(ACT_READ, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                            0, 1, 1'b0, 1'b0);
                burst_done = 1'b1;
                n += 41;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    enqueue(ACT_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                            gap, 1, 1'b0, 1'b0);
                    n++;
                end else if (pick < 53) begin
                    reps = $urandom_range(20, 60);
                    enqueue(ACT_TICK, 1'b0, DIR_STOP, gap, reps, 1'b0, 1'b0);
                    n += reps;
                end else if (pick < 66) begin
                    enqueue(ACT_SET, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                            gap, 1, 1'b0, 1'b0);
                    n++;
                end else if (pick < 94) begin
                    enqueue(ACT_READ, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                            gap, 1, (n % 300 == 299), 1'b0);
                    n++;
                end else begin
                    enqueue(ACT_NONE, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                            gap, 1, 1'b0, 1'b0);
                    n++;
                end
            end
        end
        enqueue(ACT_READ, 1'b0, DIR_STOP, 0, 1, 1'b1, 1'b0);
        enqueue(ACT_READ, 1'b1, DIR_STOP, 0, 1, 1'b0, 1'b0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_done < total_items)
            @(posedge aclk);
        while (pulses_due.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d items: %0d ticks, %0d direction sets, %0d ignored codes",
                 items_done, ticks_done, sets_done, noops_done);
        $display("checked %0d pulse counts, including full turns both ways and an output stall",
                 results_seen);
        if (faults == 0 && pulses_due.size() == 0) begin
            $display("PASS slotted_wheel_motor_encoder_model_core");
        end else begin
            $display("%0d faults", faults);
            $display("FAIL slotted_wheel_motor_encoder_model_core");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/swme_pkg.sv
hdl/slotted_wheel_motor_encoder_model_core.sv
hdl/swme_checker.sv
verif/testbench.sv
